FILE: hdl/svpp_pkg.sv
// Shared types, constants and fixed-point helpers for the star projector.
// Used by svpp_iter and star_vector_to_pixel_projector_top; no dependencies.
`default_nettype none
package svpp_pkg;

    localparam logic signed [31:0] Q_ONE      = 32'sh4000_0000;
    localparam logic signed [31:0] Q_NEG_ONE  = -32'sh4000_0000;
    localparam int                 IMAGE_SIDE_DEFAULT = 28;

    localparam logic [30:0] PITCH_RESET      = 31'd1073741;
    localparam logic [30:0] HALF_WIDTH_RESET = 31'd15032385;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_STAR  = 1'b1;

    localparam logic REG_PIXEL_PITCH = 1'b0;
    localparam logic REG_HALF_WIDTH  = 1'b1;

    typedef enum logic {
        ITR_DIV,
        ITR_SQRT
    } itr_mode_t;

    typedef struct packed {
        logic        start;
        itr_mode_t   mode;
        logic [31:0] rem_init;
        logic [63:0] num;
        logic [31:0] den;
        logic [5:0]  count;
    } itr_req_t;

    typedef struct packed {
        logic        done;
        logic [33:0] result;
    } itr_rsp_t;

    function automatic logic signed [31:0] sat_q30(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (v > Q_ONE)
            r = Q_ONE;
        else if (v < Q_NEG_ONE)
            r = Q_NEG_ONE;
        return r;
    endfunction

    function automatic logic signed [31:0] round60(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] m;
        logic [31:0] m32;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + 64'h0000_0000_2000_0000) >> 30;
        m32 = m[31:0];
        return v[63] ? signed'(32'(-m32)) : signed'(m32);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/svpp_iter.sv
// Shared restoring unit: one quotient or root bit per cycle.
// Depends on svpp_pkg for the request and response structs.
`default_nettype none
module svpp_iter
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire svpp_pkg::itr_req_t req,
    output svpp_pkg::itr_rsp_t      rsp
);

    logic                busy_reg;
    logic                done_reg;
    svpp_pkg::itr_mode_t mode_reg;
    logic [5:0]          cnt_reg;
    logic [34:0]         rem_reg;
    logic [63:0]         num_reg;
    logic [33:0]         quo_reg;
    logic [31:0]         den_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb
    begin
        if (mode_reg == svpp_pkg::ITR_SQRT)
        begin
            rem_sh = {rem_reg[33:0], num_reg[63:62]};
            trial  = {quo_reg, 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg, num_reg[63]};
            trial  = {4'b0, den_reg};
        end
        ge   = rem_sh >= trial;
        diff = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= svpp_pkg::ITR_DIV;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                cnt_reg  <= req.count;
                rem_reg  <= {3'b0, req.rem_init};
                num_reg  <= req.num;
                quo_reg  <= '0;
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[34:0] : rem_sh[34:0];
                quo_reg <= {quo_reg[32:0], ge};
                num_reg <= (mode_reg == svpp_pkg::ITR_SQRT) ? {num_reg[61:0], 2'b0}
                                                           : {num_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;

endmodule
`default_nettype wire

FILE: hdl/star_vector_to_pixel_projector_top.sv
// Star projector: frame items take squares, two 32-step roots, four 32-step divisions
// and two products, stopping after the squares when pointing on the z axis; star items
// take nine multiplies and two 34-step divisions and can be held by an output stall.
// One item at a time on the shared bit-serial divide/root unit; a finished result
// waits in the output register while the next item is taken.
// Async active-low reset: default pitch and half width, zero axes, unit yaw, no result.
`default_nettype none
module star_vector_to_pixel_projector_top
#(
    parameter int IMAGE_SIDE = svpp_pkg::IMAGE_SIDE_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               opcode,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic signed [31:0] yaw_cos,
    input  wire logic signed [31:0] yaw_sin,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [4:0]              pixel_row,
    output logic [4:0]              pixel_col,
    output logic                    in_frame,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [30:0]        cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE,
        F_M0, F_M1, F_M2, F_M3,
        F_SQR, F_SQR_W, F_SQS, F_SQS_W,
        F_DIV, F_DIV_W,
        F_P1, F_P2, F_P3,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
        S_RN, S_DC, S_DC_W, S_DR, S_DR_W, S_PUT
    } state_t;

    localparam logic [33:0] SIDE = 34'(IMAGE_SIDE);

    state_t             state_reg;
    logic [1:0]         div_sel_reg;
    logic [30:0]        pitch_reg;
    logic [30:0]        hw_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] cos_reg, sin_reg;
    logic signed [31:0] a1x_reg, a1y_reg, a2x_reg, a2y_reg, a2z_reg, u_reg;
    logic [31:0]        r_reg, s_reg;
    logic signed [63:0] acc_reg, s2_reg, x60_reg, prod_reg;
    logic signed [31:0] xp_reg, yp_reg;
    logic signed [33:0] cnum_reg, rnum_reg;
    logic [33:0]        colq_reg;
    logic               out_valid_reg;
    logic [4:0]         row_out_reg, col_out_reg;
    logic               frame_out_reg;

    logic signed [31:0] mul_a, mul_b;
    svpp_pkg::itr_req_t itr_req;
    svpp_pkg::itr_rsp_t itr_rsp;

    logic [31:0]        qd_mag, qd_den;
    logic [63:0]        qd_num;
    logic               qd_neg;
    logic [31:0]        q32;
    logic signed [31:0] q_signed;
    logic [31:0]        pitch_eff;
    logic signed [63:0] hw60;
    logic signed [63:0] col_sum, row_sum;
    logic               in_image;

    svpp_iter u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (itr_req),
        .rsp   (itr_rsp)
    );

    assign pitch_eff = (pitch_reg == '0) ? 32'd1 : {1'b0, pitch_reg};
    assign hw60      = signed'({3'b0, hw_reg, 30'b0});
    assign col_sum   = x60_reg + hw60;
    assign row_sum   = hw60 - acc_reg;
    assign q32       = itr_rsp.result[31:0];
    assign q_signed  = qd_neg ? signed'(32'(-q32)) : signed'(q32);
    assign in_image  = !cnum_reg[33] && !rnum_reg[33] && (colq_reg < SIDE)
                       && (itr_rsp.result < SIDE);

    always_comb
    begin
        case (div_sel_reg)
            2'd0:
            begin
                qd_mag = py_reg[31] ? 32'(-py_reg) : 32'(py_reg);
                qd_neg = py_reg[31];
                qd_den = r_reg;
            end
            2'd1:
            begin
                qd_mag = px_reg[31] ? 32'(-px_reg) : 32'(px_reg);
                qd_neg = !px_reg[31] && (px_reg != '0);
                qd_den = r_reg;
            end
            2'd2:
            begin
                qd_mag = pz_reg[31] ? 32'(-pz_reg) : 32'(pz_reg);
                qd_neg = pz_reg[31];
                qd_den = s_reg;
            end
            default:
            begin
                qd_mag = r_reg;
                qd_neg = 1'b1;
                qd_den = s_reg;
            end
        endcase
        qd_num = {2'b0, qd_mag, 30'b0} + {33'b0, qd_den[31:1]};
    end

    always_comb
    begin
        itr_req          = '0;
        itr_req.mode     = svpp_pkg::ITR_DIV;
        case (state_reg)
            F_SQR:
            begin
                itr_req.start = 1'b1;
                itr_req.mode  = svpp_pkg::ITR_SQRT;
                itr_req.num   = acc_reg;
                itr_req.count = 6'd32;
            end
            F_SQS:
            begin
                itr_req.start = 1'b1;
                itr_req.mode  = svpp_pkg::ITR_SQRT;
                itr_req.num   = s2_reg;
                itr_req.count = 6'd32;
            end
            F_DIV:
            begin
                itr_req.start    = 1'b1;
                itr_req.rem_init = qd_num[63:32];
                itr_req.num      = {qd_num[31:0], 32'b0};
                itr_req.den      = qd_den;
                itr_req.count    = 6'd32;
            end
            S_DC:
            begin
                itr_req.start = 1'b1;
                itr_req.num   = {cnum_reg, 30'b0};
                itr_req.den   = pitch_eff;
                itr_req.count = 6'd34;
            end
            S_DR:
            begin
                itr_req.start = 1'b1;
                itr_req.num   = {rnum_reg, 30'b0};
                itr_req.den   = pitch_eff;
                itr_req.count = 6'd34;
            end
            default:
            begin
                itr_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            F_M0:
            begin
                mul_a = px_reg; mul_b = px_reg;
            end
            F_M1:
            begin
                mul_a = py_reg; mul_b = py_reg;
            end
            F_M2:
            begin
                mul_a = pz_reg; mul_b = pz_reg;
            end
            F_P1:
            begin
                mul_a = u_reg; mul_b = -a1y_reg;
            end
            F_P2:
            begin
                mul_a = u_reg; mul_b = a1x_reg;
            end
            S_M1:
            begin
                mul_a = a1x_reg; mul_b = px_reg;
            end
            S_M2:
            begin
                mul_a = a1y_reg; mul_b = py_reg;
            end
            S_M3:
            begin
                mul_a = a2x_reg; mul_b = px_reg;
            end
            S_M4:
            begin
                mul_a = a2y_reg; mul_b = py_reg;
            end
            S_M5:
            begin
                mul_a = a2z_reg; mul_b = pz_reg;
            end
            S_M6:
            begin
                mul_a = cos_reg; mul_b = xp_reg;
            end
            S_M7:
            begin
                mul_a = sin_reg; mul_b = yp_reg;
            end
            S_M8:
            begin
                mul_a = sin_reg; mul_b = xp_reg;
            end
            S_M9:
            begin
                mul_a = cos_reg; mul_b = yp_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_sel_reg   <= '0;
            pitch_reg     <= svpp_pkg::PITCH_RESET;
            hw_reg        <= svpp_pkg::HALF_WIDTH_RESET;
            px_reg        <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
            cos_reg       <= svpp_pkg::Q_ONE;
            sin_reg       <= '0;
            a1x_reg       <= '0;
            a1y_reg       <= '0;
            a2x_reg       <= '0;
            a2y_reg       <= '0;
            a2z_reg       <= '0;
            u_reg         <= '0;
            r_reg         <= '0;
            s_reg         <= '0;
            acc_reg       <= '0;
            s2_reg        <= '0;
            x60_reg       <= '0;
            prod_reg      <= '0;
            xp_reg        <= '0;
            yp_reg        <= '0;
            cnum_reg      <= '0;
            rnum_reg      <= '0;
            colq_reg      <= '0;
            out_valid_reg <= 1'b0;
            row_out_reg   <= '0;
            col_out_reg   <= '0;
            frame_out_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;

            if (cfg_we)
            begin
                case (cfg_index)
                    svpp_pkg::REG_PIXEL_PITCH: pitch_reg <= cfg_data;
                    svpp_pkg::REG_HALF_WIDTH:  hw_reg    <= cfg_data;
                    default:                   hw_reg    <= hw_reg;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != S_PUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        px_reg <= svpp_pkg::sat_q30(vec_x);
                        py_reg <= svpp_pkg::sat_q30(vec_y);
                        pz_reg <= svpp_pkg::sat_q30(vec_z);
                        if (opcode == svpp_pkg::OP_FRAME)
                        begin
                            cos_reg   <= svpp_pkg::sat_q30(yaw_cos);
                            sin_reg   <= svpp_pkg::sat_q30(yaw_sin);
                            state_reg <= F_M0;
                        end
                        else
                        begin
                            state_reg <= S_M1;
                        end
                    end
                end
                F_M0: state_reg <= F_M1;
                F_M1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= F_M2;
                end
                F_M2:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= F_M3;
                end
                F_M3:
                begin
                    s2_reg <= acc_reg + prod_reg;
                    if (acc_reg == '0)
                    begin
                        a1x_reg   <= '0;
                        a1y_reg   <= '0;
                        a2x_reg   <= '0;
                        a2y_reg   <= '0;
                        a2z_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= F_SQR;
                    end
                end
                F_SQR: state_reg <= F_SQR_W;
                F_SQR_W:
                begin
                    if (itr_rsp.done)
                    begin
                        r_reg     <= itr_rsp.result[31:0];
                        state_reg <= F_SQS;
                    end
                end
                F_SQS: state_reg <= F_SQS_W;
                F_SQS_W:
                begin
                    if (itr_rsp.done)
                    begin
                        s_reg       <= itr_rsp.result[31:0];
                        div_sel_reg <= 2'd0;
                        state_reg   <= F_DIV;
                    end
                end
                F_DIV: state_reg <= F_DIV_W;
                F_DIV_W:
                begin
                    if (itr_rsp.done)
                    begin
                        div_sel_reg <= div_sel_reg + 2'd1;
                        state_reg   <= F_DIV;
                        case (div_sel_reg)
                            2'd0: a1x_reg <= q_signed;
                            2'd1: a1y_reg <= q_signed;
                            2'd2: u_reg   <= q_signed;
                            default:
                            begin
                                a2z_reg   <= q_signed;
                                state_reg <= F_P1;
                            end
                        endcase
                    end
                end
                F_P1: state_reg <= F_P2;
                F_P2:
                begin
                    a2x_reg   <= svpp_pkg::round60(prod_reg);
                    state_reg <= F_P3;
                end
                F_P3:
                begin
                    a2y_reg   <= svpp_pkg::round60(prod_reg);
                    state_reg <= ST_IDLE;
                end
                S_M1: state_reg <= S_M2;
                S_M2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    xp_reg    <= svpp_pkg::round60(acc_reg + prod_reg);
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    yp_reg    <= svpp_pkg::round60(acc_reg + prod_reg);
                    state_reg <= S_M7;
                end
                S_M7:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_M8;
                end
                S_M8:
                begin
                    x60_reg   <= acc_reg - prod_reg;
                    state_reg <= S_M9;
                end
                S_M9:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_M10;
                end
                S_M10:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    cnum_reg  <= col_sum[63:30];
                    state_reg <= S_RN;
                end
                S_RN:
                begin
                    rnum_reg  <= row_sum[63:30];
                    state_reg <= S_DC;
                end
                S_DC: state_reg <= S_DC_W;
                S_DC_W:
                begin
                    if (itr_rsp.done)
                    begin
                        colq_reg  <= itr_rsp.result;
                        state_reg <= S_DR;
                    end
                end
                S_DR: state_reg <= S_DR_W;
                S_DR_W:
                begin
                    if (itr_rsp.done)
                    begin
                        rnum_reg  <= in_image ? 34'(itr_rsp.result[4:0]) : 34'sh3_FFFF_FFFF;
                        colq_reg  <= in_image ? 34'(colq_reg[4:0]) : '0;
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        frame_out_reg <= !rnum_reg[33];
                        row_out_reg   <= rnum_reg[33] ? 5'd0 : rnum_reg[4:0];
                        col_out_reg   <= colq_reg[4:0];
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pixel_row = row_out_reg;
    assign pixel_col = col_out_reg;
    assign in_frame  = frame_out_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new transaction taken while an item is in progress");

    a_off_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_frame) |-> (pixel_row == '0 && pixel_col == '0))
        else $error("off-frame result carries nonzero pixel indexes");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        itr_rsp.done |-> (state_reg == F_SQR_W || state_reg == F_SQS_W
                          || state_reg == F_DIV_W || state_reg == S_DC_W
                          || state_reg == S_DR_W))
        else $error("iterative unit finished outside a wait state");
`endif

endmodule
`default_nettype wire
